### rtl/core/mbrptc_pkg.sv
`timescale 1ns / 1ps
package mbrptc_pkg;

    localparam int IN_W  = 120;
    localparam int OUT_W = 40;

    localparam logic [7:0] REG_HEAD_COUNT  = 8'd0;
    localparam logic [7:0] REG_SECTORS_TRK = 8'd1;

    localparam logic [7:0] BOOT_ACTIVE  = 8'h80;
    localparam logic [2:0] TALLY_MAX    = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CYL_GO,
        S_CYL_WAIT,
        S_HEAD_GO,
        S_HEAD_WAIT,
        S_SEC_GO,
        S_SEC_WAIT,
        S_CHECK,
        S_UPDATE,
        S_OV_RDI,
        S_OV_LATI,
        S_OV_CHKI,
        S_OV_RDJ,
        S_OV_CMPJ,
        S_RESULT
    } t_state;

    // which quotient/remainder the shared divider is producing
    typedef enum logic [1:0] {
        DIV_CYL,
        DIV_HEAD,
        DIV_SEC
    } t_div_op;

    typedef struct packed {
        logic    load;
        logic    div_start;
        t_div_op div_op;
        logic    capture;
        logic    check;
        logic    update;
        logic    lat_i;
        logic    inc_i;
        logic    rd_j;
        logic    cmp_j;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic end_sel;
        logic last_entry;
        logic i_skip;
        logic i_last;
        logic j_last;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/mbrptc_ram.sv
`timescale 1ns / 1ps
module mbrptc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/mbrptc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. A zero divisor gives an
// all-ones quotient and the dividend as remainder.
module mbrptc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [31:0] o_remainder
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dvs, n_dvs;
    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic        w_ge;

    always_comb begin
        w_shift = {r_rem, r_quo[31]};
        w_ge    = w_shift >= {1'b0, r_dvs};
        w_diff  = w_shift - {1'b0, r_dvs};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd32;
            n_quo  = i_dividend;
            n_rem  = 32'd0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[30:0], w_ge};
            n_rem = w_ge ? w_diff[31:0] : w_shift[31:0];
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### rtl/core/mbrptc_dp.sv
`timescale 1ns / 1ps
module mbrptc_dp #(
    parameter int ENTRIES = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mbrptc_pkg::t_cmd           i_cmd,
    output mbrptc_pkg::t_sts           o_sts,
    input  logic [mbrptc_pkg::IN_W-1:0] i_item,
    input  logic                       i_cfg_valid,
    input  logic [7:0]                 i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [mbrptc_pkg::OUT_W-1:0] o_out_data
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // configuration
    logic [7:0] r_head_count;
    logic [5:0] r_spt;

    // current entry
    logic [7:0]  r_flag, r_bh, r_bs, r_bc, r_fh, r_fs, r_fc;
    logic [31:0] r_base, r_cnt;
    logic        r_end;

    // division results of the end being checked
    logic [31:0] r_cyl, r_rem_g, r_srem;
    logic [7:0]  r_hd;

    // per-table accumulators
    logic [IW-1:0]      r_idx;
    logic [ENTRIES-1:0] r_base_bad, r_last_bad, r_wrap, r_overlap;
    logic [2:0]         r_tally;
    logic [7:0]         r_hh;
    logic [5:0]         r_hs;
    logic               r_seen;

    // overlap pass
    logic [IW-1:0] r_i, r_j;
    logic [31:0]   r_bi, r_ci;

    logic                     r_out_valid;
    logic [mbrptc_pkg::OUT_W-1:0] r_out_data;

    logic [13:0] w_geo;
    logic [31:0] w_lsec;
    logic [31:0] w_div_a, w_div_b;
    logic        w_div_done;
    logic [31:0] w_quo, w_rem;
    logic        w_empty;
    logic [7:0]  w_exp_hd, w_exp_sc, w_exp_cy;
    logic        w_bad;
    logic [IW-1:0] w_addr;
    logic [63:0] w_rdata;
    logic [31:0] w_bj, w_cj, w_ej, w_li;
    logic        w_hit;
    logic [32:0] w_end_sum;
    logic [7:0]  w_hh_b, w_hh_f;
    logic [5:0]  w_hs_b, w_hs_f;
    logic        w_valid;
    logic [8:0]  w_sugh;
    logic        w_geo_mm;
    logic [3:0]  w_bb4, w_lb4, w_ov4, w_wr4;

    assign w_geo  = {6'd0, r_head_count} * {8'd0, r_spt};
    assign w_lsec = r_end ? (r_base + r_cnt - 32'd1) : r_base;

    always_comb begin
        case (i_cmd.div_op)
            mbrptc_pkg::DIV_CYL: begin
                w_div_a = w_lsec;
                w_div_b = {18'd0, w_geo};
            end
            mbrptc_pkg::DIV_HEAD: begin
                w_div_a = r_rem_g;
                w_div_b = {26'd0, r_spt};
            end
            default: begin
                w_div_a = w_lsec;
                w_div_b = {26'd0, r_spt};
            end
        endcase
    end

    mbrptc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_div_a),
        .i_divisor   (w_div_b),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_addr = i_cmd.update ? r_idx : (i_cmd.rd_j ? r_j : r_i);

    mbrptc_ram #(.WIDTH(64), .DEPTH(ENTRIES)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_addr  (w_addr),
        .i_wdata ({r_cnt, r_base}),
        .o_rdata (w_rdata)
    );

    // expected CHS codes; an empty entry expects zeros at both ends
    always_comb begin
        w_empty  = (r_base == 32'd0) && (r_cnt == 32'd0);
        w_exp_hd = w_empty ? 8'd0 : r_hd;
        w_exp_cy = w_empty ? 8'd0 : r_cyl[7:0];
        w_exp_sc = w_empty ? 8'd0 : (r_srem[7:0] + 8'd1 + {r_cyl[9:8], 6'd0});
        if (r_end) begin
            w_bad = (w_exp_hd != r_fh) || (w_exp_sc != r_fs) || (w_exp_cy != r_fc);
        end else begin
            w_bad = (w_exp_hd != r_bh) || (w_exp_sc != r_bs) || (w_exp_cy != r_bc);
        end
    end

    always_comb begin
        w_bj  = w_rdata[31:0];
        w_cj  = w_rdata[63:32];
        w_ej  = w_bj + w_cj;
        w_li  = r_bi + r_ci - 32'd1;
        w_hit = ((r_bi >= w_bj) && (r_bi < w_ej)) || ((w_li >= w_bj) && (w_li < w_ej));
    end

    always_comb begin
        w_end_sum = {1'b0, r_base} + {1'b0, r_cnt};
        w_hh_b    = (r_bh > r_hh) ? r_bh : r_hh;
        w_hh_f    = (r_fh > w_hh_b) ? r_fh : w_hh_b;
        w_hs_b    = (r_bs[5:0] > r_hs) ? r_bs[5:0] : r_hs;
        w_hs_f    = (r_fs[5:0] > w_hs_b) ? r_fs[5:0] : w_hs_b;
    end

    always_comb begin
        w_valid  = (r_base_bad == '0) && (r_last_bad == '0) && (r_overlap == '0) &&
                   (r_wrap == '0) && (r_tally <= 3'd1);
        w_sugh   = {1'b0, r_hh} + 9'd1;
        w_geo_mm = r_seen && ((w_sugh != {1'b0, r_head_count}) || (r_hs != r_spt));
        w_bb4    = 4'(r_base_bad);
        w_lb4    = 4'(r_last_bad);
        w_ov4    = 4'(r_overlap);
        w_wr4    = 4'(r_wrap);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_count <= 8'd4;
            r_spt        <= 6'd17;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mbrptc_pkg::REG_HEAD_COUNT) begin
                r_head_count <= i_cfg_data;
            end else if (i_cfg_index == mbrptc_pkg::REG_SECTORS_TRK) begin
                r_spt <= i_cfg_data[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_flag <= i_item[7:0];
            r_bh   <= i_item[15:8];
            r_bs   <= i_item[23:16];
            r_bc   <= i_item[31:24];
            r_fh   <= i_item[39:32];
            r_fs   <= i_item[47:40];
            r_fc   <= i_item[55:48];
            r_base <= i_item[87:56];
            r_cnt  <= i_item[119:88];
        end
        if (i_cmd.capture) begin
            case (i_cmd.div_op)
                mbrptc_pkg::DIV_CYL: begin
                    r_cyl   <= w_quo;
                    r_rem_g <= w_rem;
                end
                mbrptc_pkg::DIV_HEAD: r_hd   <= w_quo[7:0];
                default:              r_srem <= w_rem;
            endcase
        end
        if (i_cmd.lat_i) begin
            r_bi <= w_rdata[31:0];
            r_ci <= w_rdata[63:32];
        end
        if (i_cmd.emit) begin
            r_out_data <= {3'd0, r_hs, w_sugh, w_geo_mm, r_seen, r_tally,
                           w_wr4, w_ov4, w_lb4, w_bb4, w_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end       <= 1'b0;
            r_idx       <= '0;
            r_base_bad  <= '0;
            r_last_bad  <= '0;
            r_wrap      <= '0;
            r_overlap   <= '0;
            r_tally     <= 3'd0;
            r_hh        <= 8'd0;
            r_hs        <= 6'd0;
            r_seen      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_end <= 1'b0;
            end
            if (i_cmd.check) begin
                r_end <= ~r_end;
                if (w_bad) begin
                    if (r_end) begin
                        r_last_bad[r_idx] <= 1'b1;
                    end else begin
                        r_base_bad[r_idx] <= 1'b1;
                    end
                end
            end
            if (i_cmd.update) begin
                if ((r_flag == mbrptc_pkg::BOOT_ACTIVE) && (r_tally < mbrptc_pkg::TALLY_MAX)) begin
                    r_tally <= r_tally + 3'd1;
                end
                if (r_cnt != 32'd0) begin
                    r_seen <= 1'b1;
                    r_hh   <= w_hh_f;
                    r_hs   <= w_hs_f;
                    if (w_end_sum[32]) begin
                        r_wrap[r_idx] <= 1'b1;
                    end
                end
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            if (i_cmd.lat_i) begin
                r_j <= r_i + 1'b1;
            end
            if (i_cmd.inc_i) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.cmp_j) begin
                r_j <= r_j + 1'b1;
                if (w_hit) begin
                    r_overlap[r_i] <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_idx       <= '0;
                r_base_bad  <= '0;
                r_last_bad  <= '0;
                r_wrap      <= '0;
                r_overlap   <= '0;
                r_tally     <= 3'd0;
                r_hh        <= 8'd0;
                r_hs        <= 6'd0;
                r_seen      <= 1'b0;
                r_i         <= '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.div_done   = w_div_done;
        o_sts.end_sel    = r_end;
        o_sts.last_entry = (r_idx == LAST_IDX);
        o_sts.i_last     = (r_i == LAST_IDX);
        o_sts.i_skip     = (r_ci == 32'd0) || (r_i == LAST_IDX);
        o_sts.j_last     = (r_j == LAST_IDX);
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### rtl/core/mbrptc_ctrl.sv
`timescale 1ns / 1ps
module mbrptc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mbrptc_pkg::t_sts i_sts,
    output mbrptc_pkg::t_cmd o_cmd
);

    mbrptc_pkg::t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mbrptc_pkg::S_IDLE:      if (i_in_valid) n_state = mbrptc_pkg::S_CYL_GO;
            mbrptc_pkg::S_CYL_GO:    n_state = mbrptc_pkg::S_CYL_WAIT;
            mbrptc_pkg::S_CYL_WAIT:  if (i_sts.div_done) n_state = mbrptc_pkg::S_HEAD_GO;
            mbrptc_pkg::S_HEAD_GO:   n_state = mbrptc_pkg::S_HEAD_WAIT;
            mbrptc_pkg::S_HEAD_WAIT: if (i_sts.div_done) n_state = mbrptc_pkg::S_SEC_GO;
            mbrptc_pkg::S_SEC_GO:    n_state = mbrptc_pkg::S_SEC_WAIT;
            mbrptc_pkg::S_SEC_WAIT:  if (i_sts.div_done) n_state = mbrptc_pkg::S_CHECK;
            mbrptc_pkg::S_CHECK: begin
                n_state = i_sts.end_sel ? mbrptc_pkg::S_UPDATE : mbrptc_pkg::S_CYL_GO;
            end
            mbrptc_pkg::S_UPDATE: begin
                n_state = i_sts.last_entry ? mbrptc_pkg::S_OV_RDI : mbrptc_pkg::S_IDLE;
            end
            mbrptc_pkg::S_OV_RDI:    n_state = mbrptc_pkg::S_OV_LATI;
            mbrptc_pkg::S_OV_LATI:   n_state = mbrptc_pkg::S_OV_CHKI;
            mbrptc_pkg::S_OV_CHKI: begin
                if (!i_sts.i_skip) begin
                    n_state = mbrptc_pkg::S_OV_RDJ;
                end else if (i_sts.i_last) begin
                    n_state = mbrptc_pkg::S_RESULT;
                end else begin
                    n_state = mbrptc_pkg::S_OV_RDI;
                end
            end
            mbrptc_pkg::S_OV_RDJ:    n_state = mbrptc_pkg::S_OV_CMPJ;
            mbrptc_pkg::S_OV_CMPJ: begin
                n_state = i_sts.j_last ? mbrptc_pkg::S_OV_RDI : mbrptc_pkg::S_OV_RDJ;
            end
            mbrptc_pkg::S_RESULT:    if (i_sts.out_free) n_state = mbrptc_pkg::S_IDLE;
            default:                 n_state = mbrptc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.div_op = mbrptc_pkg::DIV_CYL;
        case (r_state)
            mbrptc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mbrptc_pkg::S_CYL_GO: o_cmd.div_start = 1'b1;
            mbrptc_pkg::S_CYL_WAIT: o_cmd.capture = i_sts.div_done;
            mbrptc_pkg::S_HEAD_GO: begin
                o_cmd.div_op    = mbrptc_pkg::DIV_HEAD;
                o_cmd.div_start = 1'b1;
            end
            mbrptc_pkg::S_HEAD_WAIT: begin
                o_cmd.div_op  = mbrptc_pkg::DIV_HEAD;
                o_cmd.capture = i_sts.div_done;
            end
            mbrptc_pkg::S_SEC_GO: begin
                o_cmd.div_op    = mbrptc_pkg::DIV_SEC;
                o_cmd.div_start = 1'b1;
            end
            mbrptc_pkg::S_SEC_WAIT: begin
                o_cmd.div_op  = mbrptc_pkg::DIV_SEC;
                o_cmd.capture = i_sts.div_done;
            end
            mbrptc_pkg::S_CHECK:   o_cmd.check = 1'b1;
            mbrptc_pkg::S_UPDATE:  o_cmd.update = 1'b1;
            mbrptc_pkg::S_OV_RDI:  o_cmd.lat_i = 1'b0;
            mbrptc_pkg::S_OV_LATI: o_cmd.lat_i = 1'b1;
            mbrptc_pkg::S_OV_CHKI: o_cmd.inc_i = i_sts.i_skip && !i_sts.i_last;
            mbrptc_pkg::S_OV_RDJ:  o_cmd.rd_j = 1'b1;
            mbrptc_pkg::S_OV_CMPJ: begin
                o_cmd.cmp_j = 1'b1;
                o_cmd.inc_i = i_sts.j_last;
            end
            mbrptc_pkg::S_RESULT:  o_cmd.emit = i_sts.out_free;
            default:               o_cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbrptc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/mbr_partition_table_checker_core.sv
`timescale 1ns / 1ps
// Partition table checker: takes the ENTRIES entries of a boot record
// partition table, one transfer each, and after the last one presents a
// single verdict (CHS mismatches, overlaps, wraps, active count, suggested
// geometry). For each entry, both ends need three divisions (cylinder,
// head, sector) on one shared bit-serial divider, followed by the checks.
// The last entry adds the pairwise overlap pass over the entry store. A
// new table can be loaded while the previous verdict waits on the output
// register. Geometry must be written through the cfg port only while the
// block is idle; the block itself does not enforce this.
module mbr_partition_table_checker_core #(
    parameter int ENTRIES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // boot_flag[7:0], begin_head, begin_sector_code, begin_cylinder_code,
    // final_head, final_sector_code, final_cylinder_code[55:48],
    // base_sector[87:56], sector_count[119:88]
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // table_valid[0], base_mismatch_mask[4:1], last_mismatch_mask[8:5],
    // overlap_mask[12:9], wrap_mask[16:13], active_entries[19:17],
    // any_used[20], geometry_mismatch[21], suggested_heads[30:22],
    // suggested_sectors[36:31], zero pad
    output logic [39:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    mbrptc_pkg::t_cmd w_cmd;
    mbrptc_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    mbrptc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mbrptc_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_item      (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
